@@ design/rd3d_pkg.sv @@
// Shared types, constants and helpers for the recursive 3D video denoiser.
package rd3d_pkg;

  // Line geometry
  localparam int MAX_LINE_WIDTH = 4096;
  localparam int COL_W          = $clog2(MAX_LINE_WIDTH);

  // Curve tables: two sets (luma, chroma) of 512 signed entries
  localparam int SLOT_W      = 9;
  localparam int TABLE_DEPTH = 2 * (1 << SLOT_W);
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int TABLE_W     = 9;

  // Queue between front and back, and result queue in the back
  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_DEPTH   = 4;

  // Input word mode codes
  localparam logic [1:0] MODE_PIXEL    = 2'd0;
  localparam logic [1:0] MODE_SPATIAL  = 2'd1;
  localparam logic [1:0] MODE_TEMPORAL = 2'd2;

  // Operation kinds handed from front to back
  typedef enum logic [1:0] {
    OP_PIXEL,
    OP_SPATIAL,
    OP_TEMPORAL
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic                chroma;
    logic                sof;
    logic                sol;
    logic [7:0]          cur;
    logic [7:0]          prev;
    logic [SLOT_W-1:0]   slot;
    logic [TABLE_W-1:0]  tval;
  } op_t;

  // Table slot of a signed 9-bit difference: add the bias of 256 modulo 512
  function automatic logic [SLOT_W-1:0] bias_slot(input logic [8:0] diff);
    return {~diff[8], diff[7:0]};
  endfunction

  // Table slot addressed by a lowpass of p against c
  function automatic logic [SLOT_W-1:0] diff_slot(input logic [7:0] p, input logic [7:0] c);
    logic [8:0] d;
    d = {1'b0, p} - {1'b0, c};
    return bias_slot(d);
  endfunction

endpackage

@@ design/rd3d_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rd3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/rd3d_front.sv @@
// Front end: accepts input words, classifies them and queues operations for the back end.
module rd3d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic                chroma_plane,
  input  logic                start_of_frame,
  input  logic                start_of_line,
  input  logic [7:0]          current_pixel,
  input  logic [7:0]          previous_pixel,
  input  logic signed [8:0]   table_index,
  input  logic signed [8:0]   table_value,
  output logic                head_valid,
  output rd3d_pkg::op_t       head,
  input  logic                pop
);

  localparam int QPW = $clog2(rd3d_pkg::QUEUE_DEPTH);
  localparam int QCW = $clog2(rd3d_pkg::QUEUE_DEPTH + 1);

  rd3d_pkg::op_t  q [rd3d_pkg::QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  rd3d_pkg::op_t  op_in;
  logic           keep;
  logic           push;

  // Classify the word; drop unused mode codes
  always_comb begin
    op_in.chroma = chroma_plane;
    op_in.sof    = start_of_frame;
    op_in.sol    = start_of_line;
    op_in.cur    = current_pixel;
    op_in.prev   = previous_pixel;
    op_in.slot   = rd3d_pkg::bias_slot(table_index);
    op_in.tval   = table_value;
    keep         = 1'b1;
    unique case (mode)
      rd3d_pkg::MODE_PIXEL:    op_in.kind = rd3d_pkg::OP_PIXEL;
      rd3d_pkg::MODE_SPATIAL:  op_in.kind = rd3d_pkg::OP_SPATIAL;
      rd3d_pkg::MODE_TEMPORAL: op_in.kind = rd3d_pkg::OP_TEMPORAL;
      default: begin
        op_in.kind = rd3d_pkg::OP_PIXEL;
        keep       = 1'b0;
      end
    endcase
  end

  assign in_ready   = (count != QCW'(rd3d_pkg::QUEUE_DEPTH));
  assign push       = in_valid && in_ready && keep;
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];

  // Store pushed operations
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= op_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(rd3d_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(rd3d_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/rd3d_back.sv @@
// Back end: table writes and the horizontal, vertical and temporal lowpass pipeline.
module rd3d_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  rd3d_pkg::op_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    filtered_pixel
);

  localparam int COL_W = rd3d_pkg::COL_W;
  localparam int TAW   = rd3d_pkg::TABLE_AW;
  localparam int OPW   = $clog2(rd3d_pkg::OUT_DEPTH);
  localparam int OCW   = $clog2(rd3d_pkg::OUT_DEPTH + 1);

  // Line state
  logic [COL_W-1:0] column;
  logic [COL_W-1:0] column_next;
  logic             first_row;
  logic [7:0]       left;
  logic [7:0]       left_next;

  // Issue control
  logic             issue_pix;
  logic             issue_tab;
  logic             space_ok;
  logic [OCW:0]     credit_sum;
  logic             hpass;
  logic             vpass;

  // Stage B: horizontal pass
  logic             b_vld;
  logic [7:0]       b_cur, b_prev;
  logic             b_set, b_hpass, b_vpass;
  logic [COL_W-1:0] b_col;
  logic [7:0]       b_lval;

  // Stage C: vertical table address
  logic             c_vld;
  logic [7:0]       c_left, c_lval, c_prev;
  logic             c_set, c_vpass;
  logic [COL_W-1:0] c_col;

  // Stage D: vertical pass, line write, temporal address
  logic             d_vld;
  logic [7:0]       d_left, d_prev;
  logic             d_set, d_vpass;
  logic [COL_W-1:0] d_col;
  logic [7:0]       d_s;

  // Stage E: temporal pass
  logic             e_vld;
  logic [7:0]       e_s;
  logic [COL_W-1:0] e_col;
  logic [7:0]       e_result;

  // Memory ports
  logic [rd3d_pkg::TABLE_W-1:0] h_rdata, v_rdata, t_rdata;
  logic [7:0]                   l_rdata;
  logic [TAW-1:0]               tab_waddr;
  logic                         sp_we, tp_we;

  // Result queue
  logic [7:0]     oq [rd3d_pkg::OUT_DEPTH];
  logic [OPW-1:0] oq_wr, oq_rd;
  logic [OCW-1:0] oq_count;
  logic           oq_pop;

  // Reserve a result slot for every pixel still in flight
  assign credit_sum = (OCW+1)'(oq_count) + (OCW+1)'(b_vld) + (OCW+1)'(c_vld)
                    + (OCW+1)'(d_vld) + (OCW+1)'(e_vld);
  assign space_ok   = credit_sum < (OCW+1)'(rd3d_pkg::OUT_DEPTH);

  // Pixels wait for the left result; table writes wait until no pixel still reads the tables
  assign issue_pix = head_valid && (head.kind == rd3d_pkg::OP_PIXEL) && !b_vld && space_ok;
  assign issue_tab = head_valid && (head.kind != rd3d_pkg::OP_PIXEL) && !b_vld && !c_vld
                  && !d_vld;
  assign pop       = issue_pix || issue_tab;

  assign tab_waddr = {head.chroma, head.slot};
  assign sp_we     = issue_tab && (head.kind == rd3d_pkg::OP_SPATIAL);
  assign tp_we     = issue_tab && (head.kind == rd3d_pkg::OP_TEMPORAL);

  // Column for the issued pixel, saturating at the end of the line store
  always_comb begin
    priority if (head.sof || head.sol) begin
      column_next = '0;
    end else if (column < COL_W'(rd3d_pkg::MAX_LINE_WIDTH - 1)) begin
      column_next = column + 1'b1;
    end else begin
      column_next = column;
    end
  end

  assign hpass = !head.sof && !head.sol;
  assign vpass = !head.sof && (head.sol || !first_row);

  // Hold line position and row state
  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      first_row <= 1'b1;
    end else if (issue_pix) begin
      column <= column_next;
      if (head.sof) begin
        first_row <= 1'b1;
      end else if (head.sol) begin
        first_row <= 1'b0;
      end
    end
  end

  // Horizontal pass and left result
  assign left_next = b_hpass ? (b_cur + h_rdata[7:0]) : b_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (b_vld) begin
      left <= left_next;
    end
  end

  // Forward line entries not yet visible in the line store
  always_comb begin
    priority if (d_vld && (d_col == b_col)) begin
      b_lval = d_s;
    end else if (e_vld && (e_col == b_col)) begin
      b_lval = e_s;
    end else begin
      b_lval = l_rdata;
    end
  end

  assign d_s      = d_vpass ? (d_left + v_rdata[7:0]) : d_left;
  assign e_result = e_s + t_rdata[7:0];

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
    end else begin
      b_vld <= issue_pix;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    b_cur   <= head.cur;
    b_prev  <= head.prev;
    b_set   <= head.chroma;
    b_col   <= column_next;
    b_hpass <= hpass;
    b_vpass <= vpass;

    c_left  <= left_next;
    c_lval  <= b_lval;
    c_prev  <= b_prev;
    c_set   <= b_set;
    c_col   <= b_col;
    c_vpass <= b_vpass;

    d_left  <= c_left;
    d_prev  <= c_prev;
    d_set   <= c_set;
    d_col   <= c_col;
    d_vpass <= c_vpass;

    e_s     <= d_s;
    e_col   <= d_col;
  end

  // Spatial table copy read by the horizontal pass
  rd3d_ram #(.WIDTH(rd3d_pkg::TABLE_W), .DEPTH(rd3d_pkg::TABLE_DEPTH)) u_sp_h (
    .clk   (clk),
    .we    (sp_we),
    .waddr (tab_waddr),
    .wdata (head.tval),
    .raddr ({head.chroma, rd3d_pkg::diff_slot(left, head.cur)}),
    .rdata (h_rdata)
  );

  // Spatial table copy read by the vertical pass
  rd3d_ram #(.WIDTH(rd3d_pkg::TABLE_W), .DEPTH(rd3d_pkg::TABLE_DEPTH)) u_sp_v (
    .clk   (clk),
    .we    (sp_we),
    .waddr (tab_waddr),
    .wdata (head.tval),
    .raddr ({c_set, rd3d_pkg::diff_slot(c_lval, c_left)}),
    .rdata (v_rdata)
  );

  // Temporal table
  rd3d_ram #(.WIDTH(rd3d_pkg::TABLE_W), .DEPTH(rd3d_pkg::TABLE_DEPTH)) u_tp (
    .clk   (clk),
    .we    (tp_we),
    .waddr (tab_waddr),
    .wdata (head.tval),
    .raddr ({d_set, rd3d_pkg::diff_slot(d_prev, d_s)}),
    .rdata (t_rdata)
  );

  // Line of spatial results
  rd3d_ram #(.WIDTH(8), .DEPTH(rd3d_pkg::MAX_LINE_WIDTH)) u_line (
    .clk   (clk),
    .we    (d_vld),
    .waddr (d_col),
    .wdata (d_s),
    .raddr (column_next),
    .rdata (l_rdata)
  );

  // Result queue
  assign out_valid      = (oq_count != '0);
  assign filtered_pixel = oq[oq_rd];
  assign oq_pop         = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (e_vld) begin
      oq[oq_wr] <= e_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (e_vld) begin
        oq_wr <= (oq_wr == OPW'(rd3d_pkg::OUT_DEPTH - 1)) ? '0 : oq_wr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd <= (oq_rd == OPW'(rd3d_pkg::OUT_DEPTH - 1)) ? '0 : oq_rd + 1'b1;
      end
      if (e_vld && !oq_pop) begin
        oq_count <= oq_count + 1'b1;
      end else if (oq_pop && !e_vld) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

endmodule

@@ design/recursive_3d_video_denoise_top.sv @@
// Top level of the recursive spatio-temporal video denoiser.
//
//   channel | handshake           | word
//   --------+---------------------+----------------------------------------------
//   in      | in_valid / in_ready | mode, chroma_plane, start_of_frame,
//           |                     | start_of_line, current_pixel, previous_pixel,
//           |                     | table_index, table_value
//   out     | out_valid/out_ready | filtered_pixel
//
// A pixel does not issue while the one before it is in stage B: the horizontal
// pass needs the left result back through a registered spatial table read before
// the next pixel can start. Pixels pass stages B, C, D and E to the result queue;
// table writes issue once no pixel in stages B, C or D still reads the tables.
// Reset clears control state only; tables and line store hold garbage until written.
// A full 4-entry result queue holds pixels in the 2-entry input queue; mode 3 words
// are accepted and dropped.
module recursive_3d_video_denoise_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  input  logic              chroma_plane,
  input  logic              start_of_frame,
  input  logic              start_of_line,
  input  logic [7:0]        current_pixel,
  input  logic [7:0]        previous_pixel,
  input  logic signed [8:0] table_index,
  input  logic signed [8:0] table_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        filtered_pixel
);

  logic          head_valid;
  rd3d_pkg::op_t head;
  logic          pop;

  // Accept and classify words
  rd3d_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .chroma_plane   (chroma_plane),
    .start_of_frame (start_of_frame),
    .start_of_line  (start_of_line),
    .current_pixel  (current_pixel),
    .previous_pixel (previous_pixel),
    .table_index    (table_index),
    .table_value    (table_value),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop)
  );

  // Execute table writes and filter pixels
  rd3d_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_pixel (filtered_pixel)
  );

endmodule

@@ design/rd3d_checker.sv @@
// Port checker for the denoiser top level, attached by bind.
module rd3d_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] filtered_pixel
);

  // Reset empties the result queue
  a_reset_no_result: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word shown right after reset");

  // Reset empties the input queue
  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready right after reset");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_pixel))
    else $error("stalled result word changed or vanished");

endmodule

bind recursive_3d_video_denoise_top rd3d_checker u_rd3d_checker (.*);
